[rtl/ralu_pkg.sv]
// Shared types and constants for the R-type ALU with register file.
package ralu_pkg;

  // Fixed field widths of the item ports
  localparam int IDX_W = 5;
  localparam int OP_W  = 4;
  localparam int PC_W  = 32;
  localparam int VAL_W = 32;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_NOR     = 4'd0,
    OP_OR      = 4'd1,
    OP_XOR     = 4'd2,
    OP_AND     = 4'd3,
    OP_NAND    = 4'd4,
    OP_SLT     = 4'd5,
    OP_JR      = 4'd6,
    OP_SLL     = 4'd7,
    OP_SRL     = 4'd8,
    OP_SRA     = 4'd9,
    OP_ADD     = 4'd10,
    OP_SUB     = 4'd11,
    OP_PRELOAD = 4'd12
  } op_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // latch the input word and issue register reads
    logic exec;     // execute, write back and load the result register
    logic retire;   // result register is taken by the sink
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

[rtl/ralu_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
module ralu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/ralu_ctrl.sv]
// Controller state machine: sequences accept, execute and result hand-off.
module ralu_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   out_stall,
  input  ralu_pkg::dp_status_t   status,
  output ralu_pkg::dp_cmd_t      cmd
);
  import ralu_pkg::*;

  state_t state, state_next;
  logic   out_free;

  // Result register can take a new word when empty or being drained
  assign out_free = !status.out_full || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    cmd.retire = status.out_full && !out_stall;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_EXEC))
    else $error("accepted word did not move to execute");

  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && !cmd.exec |=> (state == ST_EXEC))
    else $error("execute left without writing the result");

  a_no_exec_when_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(status.out_full && out_stall))
    else $error("execute overwrote a pending result");

endmodule

[rtl/ralu_datapath.sv]
// Datapath: register file, operand latch, ALU, pc and result register.
module ralu_datapath #(
  parameter int NUM_REGS   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ralu_pkg::dp_cmd_t             cmd,
  output ralu_pkg::dp_status_t          status,
  input  logic [ralu_pkg::OP_W-1:0]     operation,
  input  logic [ralu_pkg::IDX_W-1:0]    src_a,
  input  logic [ralu_pkg::IDX_W-1:0]    src_b,
  input  logic [ralu_pkg::IDX_W-1:0]    dest,
  input  logic [ralu_pkg::IDX_W-1:0]    shift_amount,
  input  logic [ralu_pkg::VAL_W-1:0]    preload_value,
  output logic                          written,
  output logic [ralu_pkg::IDX_W-1:0]    written_index,
  output logic [ralu_pkg::VAL_W-1:0]    written_value,
  output logic                          overflow,
  output logic                          jumped,
  output logic [ralu_pkg::PC_W-1:0]     program_counter
);
  import ralu_pkg::*;

  localparam int AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MSB = DATA_WIDTH - 1;

  // Latched instruction word
  op_t                   op_q;
  logic [IDX_W-1:0]      dest_q;
  logic [IDX_W-1:0]      sh_q;
  logic [DATA_WIDTH-1:0] pre_q;
  logic                  a_ok, b_ok;

  logic [NUM_REGS-1:0]   vld;
  logic [DATA_WIDTH-1:0] rd_a, rd_b, a, b, val, sum, diff;
  logic                  wr, ovf, jmp, wr_ok, dest_ok;
  logic                  a_in_range, b_in_range;
  logic [AW-1:0]         raddr_a, raddr_b, waddr;
  logic                  out_full;
  logic [PC_W-1:0]       pc;

  assign raddr_a    = AW'(src_a);
  assign raddr_b    = AW'(src_b);
  assign waddr      = AW'(dest_q);
  assign a_in_range = 32'(src_a) < 32'(NUM_REGS);
  assign b_in_range = 32'(src_b) < 32'(NUM_REGS);
  assign dest_ok    = 32'(dest_q) < 32'(NUM_REGS);

  // Register file storage
  ralu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_rf (
    .clk     (clk),
    .we      (cmd.exec && wr_ok),
    .waddr   (waddr),
    .wdata   (val),
    .re      (cmd.accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Written-since-reset bits; an unwritten register reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.exec && wr_ok) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op_t'(operation);
      dest_q <= dest;
      sh_q   <= shift_amount;
      pre_q  <= DATA_WIDTH'(preload_value);
      a_ok   <= a_in_range && vld[raddr_a];
      b_ok   <= b_in_range && vld[raddr_b];
    end
  end

  assign a    = a_ok ? rd_a : '0;
  assign b    = b_ok ? rd_b : '0;
  assign sum  = a + b;
  assign diff = a - b;

  // ALU
  always_comb begin
    val = '0;
    wr  = 1'b0;
    ovf = 1'b0;
    jmp = 1'b0;
    unique case (op_q)
      OP_NOR:     begin val = ~(a | b); wr = 1'b1; end
      OP_OR:      begin val = a | b;    wr = 1'b1; end
      OP_XOR:     begin val = a ^ b;    wr = 1'b1; end
      OP_AND:     begin val = a & b;    wr = 1'b1; end
      OP_NAND:    begin val = ~(a & b); wr = 1'b1; end
      OP_SLT: begin
        val = DATA_WIDTH'($signed(a) < $signed(b));
        wr  = 1'b1;
      end
      OP_JR:      jmp = 1'b1;
      OP_SLL:     begin val = b << sh_q; wr = 1'b1; end
      OP_SRL:     begin val = b >> sh_q; wr = 1'b1; end
      OP_SRA: begin
        val = DATA_WIDTH'($signed(b) >>> sh_q);
        wr  = 1'b1;
      end
      OP_ADD: begin
        val = sum;
        ovf = (a[MSB] == b[MSB]) && (sum[MSB] != a[MSB]);
        wr  = !ovf;
      end
      OP_SUB: begin
        val = diff;
        ovf = (a[MSB] != b[MSB]) && (diff[MSB] != a[MSB]);
        wr  = !ovf;
      end
      OP_PRELOAD: begin val = pre_q; wr = 1'b1; end
      default: begin
        val = '0;
      end
    endcase
  end

  assign wr_ok = wr && dest_ok;

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (cmd.exec && jmp) begin
      pc <= PC_W'(a);
    end
  end
  assign program_counter = pc;

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      written       <= wr_ok;
      written_index <= wr_ok ? dest_q : '0;
      written_value <= wr_ok ? VAL_W'(val) : '0;
      overflow      <= ovf;
      jumped        <= jmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.exec) begin
      out_full <= 1'b1;
    end else if (cmd.retire) begin
      out_full <= 1'b0;
    end
  end
  assign status.out_full = out_full;

  // Checks
  a_exec_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_full)
    else $error("result register not loaded after execute");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !(written && (overflow || jumped)))
    else $error("write flagged together with overflow or jump");

  a_pc_only_on_jump: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.exec && jmp) && !$past(rst) |-> $stable(pc))
    else $error("pc changed without a jump");

endmodule

[rtl/rtype_alu_with_register_file.sv]
// Top level: R-type execute unit with register file.
// Executes one R-type word per item against a NUM_REGS x DATA_WIDTH register
// file (all zeros after reset) and a 32-bit pc. An accepted word reads rs and
// rt from the two read ports of the register-file RAM in the idle state and
// executes, writes back and loads the result register in the execute state;
// the registered RAM read is why these are separate, and no new word is taken
// while one is in execute. The next word is taken as soon as the
// previous one has executed, while its result may still wait in the output
// register; execution stalls only when that register is still held. Result
// words carry the write flag, index and value, the overflow and jump flags,
// and the pc after the item. Unused operation codes change nothing.
module rtype_alu_with_register_file #(
  parameter int NUM_REGS   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ralu_pkg::OP_W-1:0]     operation,
  input  logic [ralu_pkg::IDX_W-1:0]    src_a,
  input  logic [ralu_pkg::IDX_W-1:0]    src_b,
  input  logic [ralu_pkg::IDX_W-1:0]    dest,
  input  logic [ralu_pkg::IDX_W-1:0]    shift_amount,
  input  logic [ralu_pkg::VAL_W-1:0]    preload_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          written,
  output logic [ralu_pkg::IDX_W-1:0]    written_index,
  output logic [ralu_pkg::VAL_W-1:0]    written_value,
  output logic                          overflow,
  output logic                          jumped,
  output logic [ralu_pkg::PC_W-1:0]     program_counter
);
  import ralu_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ralu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ralu_datapath #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .src_a           (src_a),
    .src_b           (src_b),
    .dest            (dest),
    .shift_amount    (shift_amount),
    .preload_value   (preload_value),
    .written         (written),
    .written_index   (written_index),
    .written_value   (written_value),
    .overflow        (overflow),
    .jumped          (jumped),
    .program_counter (program_counter)
  );

  assign out_valid = status.out_full;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the R-type ALU with register file: directed table, then random words.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ralu_pkg::*;

  // Operation codes the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd13;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  localparam int RAND_PER_PHASE = 390;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int MAX_REPORTS    = 10;

  // Expected write-back word
  typedef struct packed {
    logic             written;
    logic [IDX_W-1:0] wr_index;
    logic [VAL_W-1:0] wr_value;
    logic             ovf;
    logic             jmp;
    logic [PC_W-1:0]  pc;
  } result_t;

  // One row of the directed table
  typedef struct {
    bit               known;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] rd;
    logic [IDX_W-1:0] sh;
    logic [VAL_W-1:0] pv;
    result_t          res;
  } dir_row_t;

  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_HOLD} phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  operation = '0;
  logic [IDX_W-1:0] src_a = '0;
  logic [IDX_W-1:0] src_b = '0;
  logic [IDX_W-1:0] dest = '0;
  logic [IDX_W-1:0] shift_amount = '0;
  logic [VAL_W-1:0] preload_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             written;
  logic [IDX_W-1:0] written_index;
  logic [VAL_W-1:0] written_value;
  logic             overflow;
  logic             jumped;
  logic [PC_W-1:0]  program_counter;

  // Shadow architectural state
  logic [VAL_W-1:0] shadow_regs [32];
  logic [PC_W-1:0]  shadow_pc;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  int       fail_count = 0;
  int       src_idle_pct = 0;
  int       snk_stall_pct = 0;
  phase_t   cur_phase = PH_FREE;
  bit       hold_on = 1'b0;

  rtype_alu_with_register_file uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .src_a           (src_a),
    .src_b           (src_b),
    .dest            (dest),
    .shift_amount    (shift_amount),
    .preload_value   (preload_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .written         (written),
    .written_index   (written_index),
    .written_value   (written_value),
    .overflow        (overflow),
    .jumped          (jumped),
    .program_counter (program_counter)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Execute one word on the shadow state and return its write-back word
  function automatic result_t execute_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] ra,
                                           logic [IDX_W-1:0] rb, logic [IDX_W-1:0] rd,
                                           logic [IDX_W-1:0] sh, logic [VAL_W-1:0] pv);
    logic [VAL_W-1:0] a, b, val;
    bit wr, ovf, jmp;
    result_t r;
    a = shadow_regs[ra];
    b = shadow_regs[rb];
    val = '0;
    wr = 1'b0;
    ovf = 1'b0;
    jmp = 1'b0;
    case (op)
      OP_NOR:     begin val = ~(a | b); wr = 1'b1; end
      OP_OR:      begin val = a | b; wr = 1'b1; end
      OP_XOR:     begin val = a ^ b; wr = 1'b1; end
      OP_AND:     begin val = a & b; wr = 1'b1; end
      OP_NAND:    begin val = ~(a & b); wr = 1'b1; end
      OP_SLT:     begin val = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1'b1; end
      OP_JR:      begin shadow_pc = a; jmp = 1'b1; end
      OP_SLL:     begin val = b << sh; wr = 1'b1; end
      OP_SRL:     begin val = b >> sh; wr = 1'b1; end
      OP_SRA:     begin val = $signed(b) >>> sh; wr = 1'b1; end
      OP_ADD: begin
        val = a + b;
        ovf = (a[VAL_W-1] == b[VAL_W-1]) && (val[VAL_W-1] != a[VAL_W-1]);
        wr = !ovf;
      end
      OP_SUB: begin
        val = a - b;
        ovf = (a[VAL_W-1] != b[VAL_W-1]) && (val[VAL_W-1] != a[VAL_W-1]);
        wr = !ovf;
      end
      OP_PRELOAD: begin val = pv; wr = 1'b1; end
      default: ;
    endcase
    if (wr) shadow_regs[rd] = val;
    r.written  = wr;
    r.wr_index = wr ? rd : '0;
    r.wr_value = wr ? val : '0;
    r.ovf      = ovf;
    r.jmp      = jmp;
    r.pc       = shadow_pc;
    return r;
  endfunction

  function automatic result_t mk_res(bit w, logic [IDX_W-1:0] wi, logic [VAL_W-1:0] wv,
                                     bit ov, bit jp, logic [PC_W-1:0] pcv);
    result_t r;
    r.written  = w;
    r.wr_index = wi;
    r.wr_value = wv;
    r.ovf      = ov;
    r.jmp      = jp;
    r.pc       = pcv;
    return r;
  endfunction

  task automatic add_row(bit known, logic [OP_W-1:0] op, logic [IDX_W-1:0] ra,
                         logic [IDX_W-1:0] rb, logic [IDX_W-1:0] rd, logic [IDX_W-1:0] sh,
                         logic [VAL_W-1:0] pv, result_t res);
    dir_row_t row;
    row.known = known;
    row.op    = op;
    row.ra    = ra;
    row.rb    = rb;
    row.rd    = rd;
    row.sh    = sh;
    row.pv    = pv;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Offer one word, with random idle cycles first, and return once it is taken
  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] ra, logic [IDX_W-1:0] rb,
                           logic [IDX_W-1:0] rd, logic [IDX_W-1:0] sh, logic [VAL_W-1:0] pv);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    src_a         <= ra;
    src_b         <= rb;
    dest          <= rd;
    shift_amount  <= sh;
    preload_value <= pv;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly low registers so that reads land right behind recent writes
  function automatic logic [IDX_W-1:0] pick_reg();
    if ($urandom_range(1) == 0) return IDX_W'($urandom_range(3));
    return IDX_W'($urandom_range(31));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      5: return 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  // Long hold-off once, so the block backs up into its input
  initial begin
    wait (cur_phase == PH_HOLD);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Result side: check taken words, then choose the next stall
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = mk_res(written, written_index, written_value, overflow, jumped, program_counter);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected word: w=%0b idx=%0d val=%h ovf=%0b jmp=%0b pc=%h",
                   got.written, got.wr_index, got.wr_value, got.ovf, got.jmp, got.pc);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"mismatch: exp w=%0b idx=%0d val=%h ovf=%0b jmp=%0b pc=%h",
                      " / got w=%0b idx=%0d val=%h ovf=%0b jmp=%0b pc=%h"},
                     want.written, want.wr_index, want.wr_value, want.ovf, want.jmp, want.pc,
                     got.written, got.wr_index, got.wr_value, got.ovf, got.jmp, got.pc);
        end
      end
    end
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= (snk_stall_pct != 0) && ($urandom_range(99) < snk_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    dir_row_t         row;
    result_t          pred;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] pv;
    int               sel;
    int               drain;

    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_pc = '0;

    // Directed table: typed results where obvious, predictor elsewhere
    add_row(1, OP_NOR, 5, 6, 7, 0, 0, mk_res(1, 7, 32'hFFFF_FFFF, 0, 0, 0));
    add_row(1, OP_PRELOAD, 0, 0, 1, 0, 32'h7FFF_FFFF, mk_res(1, 1, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(1, OP_PRELOAD, 0, 0, 2, 0, 32'h8000_0000, mk_res(1, 2, 32'h8000_0000, 0, 0, 0));
    add_row(1, OP_PRELOAD, 0, 0, 3, 0, 32'h0000_0001, mk_res(1, 3, 32'h0000_0001, 0, 0, 0));
    add_row(1, OP_PRELOAD, 0, 0, 4, 0, 32'hFFFF_FFFF, mk_res(1, 4, 32'hFFFF_FFFF, 0, 0, 0));
    add_row(1, OP_PRELOAD, 0, 0, 31, 0, 32'hA5A5_A5A5, mk_res(1, 31, 32'hA5A5_A5A5, 0, 0, 0));
    // signed overflow on add and sub drops the write
    add_row(1, OP_ADD, 1, 3, 8, 0, 0, mk_res(0, 0, 0, 1, 0, 0));
    add_row(1, OP_SUB, 2, 3, 8, 0, 0, mk_res(0, 0, 0, 1, 0, 0));
    add_row(1, OP_ADD, 2, 2, 9, 0, 0, mk_res(0, 0, 0, 1, 0, 0));
    add_row(0, OP_ADD, 1, 4, 10, 0, 0, '0);
    add_row(0, OP_SUB, 1, 4, 10, 0, 0, '0);
    add_row(0, OP_OR, 2, 3, 11, 0, 0, '0);
    add_row(0, OP_XOR, 31, 4, 12, 0, 0, '0);
    add_row(0, OP_AND, 31, 1, 13, 0, 0, '0);
    // register zero is an ordinary register
    add_row(0, OP_NAND, 4, 4, 0, 0, 0, '0);
    add_row(1, OP_SLT, 2, 1, 14, 0, 0, mk_res(1, 14, 32'h1, 0, 0, 0));
    add_row(0, OP_SLT, 1, 2, 15, 0, 0, '0);
    add_row(1, OP_SLL, 0, 4, 16, 31, 0, mk_res(1, 16, 32'h8000_0000, 0, 0, 0));
    add_row(1, OP_SRL, 0, 2, 17, 31, 0, mk_res(1, 17, 32'h1, 0, 0, 0));
    add_row(1, OP_SRA, 0, 2, 18, 31, 0, mk_res(1, 18, 32'hFFFF_FFFF, 0, 0, 0));
    add_row(0, OP_SRA, 0, 31, 19, 0, 0, '0);
    add_row(1, OP_JR, 4, 0, 20, 0, 0, mk_res(0, 0, 0, 0, 1, 32'hFFFF_FFFF));
    add_row(1, OP_UNUSED_LO, 1, 2, 21, 5, 32'hFFFF_FFFF, mk_res(0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_row(1, OP_UNUSED_HI, 31, 31, 31, 31, 32'hFFFF_FFFF, mk_res(0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_row(0, OP_JR, 0, 0, 0, 0, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.op, row.ra, row.rb, row.rd, row.sh, row.pv);
      pred = execute_word(row.op, row.ra, row.rb, row.rd, row.sh, row.pv);
      pending_results.push_back(row.known ? row.res : pred);
    end

    // Random words, one block per idling pattern
    for (int p = PH_FREE; p <= PH_HOLD; p++) begin
      cur_phase = phase_t'(p);
      case (cur_phase)
        PH_SRC_IDLE:  begin src_idle_pct = 57; snk_stall_pct = 0;  end
        PH_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 57; end
        PH_BOTH:      begin src_idle_pct = 15; snk_stall_pct = 15; end
        default:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        sel = $urandom_range(99);
        if (sel < 25)
          op = OP_PRELOAD;
        else if (sel < 29)
          op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else
          op = OP_W'($urandom_range(OP_SUB, OP_NOR));
        pv = (op == OP_PRELOAD) ? pick_value() : $urandom;
        send_word(op, pick_reg(), pick_reg(), pick_reg(), IDX_W'($urandom_range(31)), pv);
        pending_results.push_back(execute_word(operation, src_a, src_b, dest,
                                               shift_amount, preload_value));
      end
    end

    // Drain outstanding results
    in_valid <= 1'b0;
    cur_phase = PH_FREE;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    fail_count += pending_results.size();

    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
